// ===== sv/dfpa_pkg.sv =====
package dfpa_pkg;

  localparam int FRAC_BITS_DEF = 7;
  localparam int INT_BITS_DEF  = 9;

  localparam int WORD_W = 16;
  localparam int HUND_W = 16;
  localparam int PROD_W = 2 * HUND_W;
  localparam int DVD_W  = 23;
  localparam int TOT_W  = 25;
  localparam int QE_W   = 26;
  localparam int IP_W   = 19;

  localparam int RECIP_SHIFT = 35;
  localparam logic [30:0] RECIP25 = 31'd1374389534;
  localparam logic [7:0] HUNDRED8 = 8'd100;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              dz;
    logic [TOT_W-1:0]  val;
    logic [HUND_W-1:0] rem;
    logic [HUND_W-1:0] dvs;
  } dfpa_word_t;

endpackage

// ===== sv/decimal_fixed_point_alu.sv =====
// Decimal fixed-point ALU: add, subtract (clamped at zero), multiply and divide on
// operands packed as integer part over hundredths. Fully pipelined: one word is
// accepted per cycle while the output is not stalled, and each result passes the
// front stages, then the restoring divider, a row of 23 cells that each settle one
// quotient bit, then the back stages. Bubbles collapse, so new words keep
// entering while a finished result waits at the output.
module decimal_fixed_point_alu import dfpa_pkg::*; #(
  parameter int FRAC_FIELD_BITS = FRAC_BITS_DEF,
  parameter int INT_FIELD_BITS  = INT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        opcode,
  input  logic [WORD_W-1:0] operand_a,
  input  logic [WORD_W-1:0] operand_b,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] result_word,
  output logic              overflow_flag,
  output logic              divide_by_zero_flag
);

  logic       cv [DVD_W+1];
  logic       cr [DVD_W+1];
  dfpa_word_t cw [DVD_W+1];

  dfpa_front #(
    .FRAC_FIELD_BITS(FRAC_FIELD_BITS),
    .INT_FIELD_BITS (INT_FIELD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .operand_a(operand_a),
    .operand_b(operand_b),
    .out_valid(cv[0]),
    .out_ready(cr[0]),
    .out_word (cw[0])
  );

  for (genvar i = 0; i < DVD_W; i++) begin : g_cell
    dfpa_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (cv[i]),
      .in_ready (cr[i]),
      .in_word  (cw[i]),
      .out_valid(cv[i+1]),
      .out_ready(cr[i+1]),
      .out_word (cw[i+1])
    );
  end

  dfpa_back #(
    .FRAC_FIELD_BITS(FRAC_FIELD_BITS),
    .INT_FIELD_BITS (INT_FIELD_BITS)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (cv[DVD_W]),
    .in_ready           (cr[DVD_W]),
    .in_word            (cw[DVD_W]),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .result_word        (result_word),
    .overflow_flag      (overflow_flag),
    .divide_by_zero_flag(divide_by_zero_flag)
  );

endmodule

// ===== sv/dfpa_front.sv =====
module dfpa_front import dfpa_pkg::*; #(
  parameter int FRAC_FIELD_BITS = FRAC_BITS_DEF,
  parameter int INT_FIELD_BITS  = INT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        opcode,
  input  logic [WORD_W-1:0] operand_a,
  input  logic [WORD_W-1:0] operand_b,
  output logic              out_valid,
  input  logic              out_ready,
  output dfpa_word_t        out_word
);

  localparam logic [HUND_W-1:0] IMASK = (INT_FIELD_BITS >= HUND_W) ? '1 :
    HUND_W'((64'd1 << INT_FIELD_BITS) - 64'd1);
  localparam logic [HUND_W-1:0] FMASK = HUND_W'((64'd1 << FRAC_FIELD_BITS) - 64'd1);

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  op_t               op1, op2, op3;
  logic [HUND_W-1:0] a1, b1, b2, b3;
  logic              dz2, dz3;
  logic [TOT_W-1:0]  val2, val3;
  logic [PROD_W-1:0] prod2, prod3;
  logic [QE_W-1:0]   qe3;

  logic [HUND_W-1:0]  ip_a, ip_b, a_in, b_in;
  logic [TOT_W-1:0]   tot;
  logic [60:0]        mq;
  logic [7:0]         r8;
  logic               fix;
  logic [TOT_W-1:0]   mval;

  assign en4 = !v4 || out_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready  = en1;
  assign out_valid = v4;

  always_comb begin
    ip_a = (operand_a >> FRAC_FIELD_BITS) & IMASK;
    ip_b = (operand_b >> FRAC_FIELD_BITS) & IMASK;
    a_in = HUND_W'(ip_a * 16'd100) + (operand_a & FMASK);
    b_in = HUND_W'(ip_b * 16'd100) + (operand_b & FMASK);
    unique case (op1)
      OP_ADD: tot = TOT_W'(a1) + TOT_W'(b1);
      OP_SUB: tot = (a1 < b1) ? '0 : TOT_W'(a1 - b1);
      OP_MUL: tot = '0;
      OP_DIV: tot = TOT_W'(DVD_W'(a1) * DVD_W'(100));
      default: tot = '0;
    endcase
    mq   = 61'(prod2[PROD_W-1:2]) * 61'(RECIP25);
    r8   = prod3[7:0] - 8'(qe3[7:0] * HUNDRED8);
    fix  = (r8 >= HUNDRED8);
    mval = (op3 == OP_MUL) ? TOT_W'(qe3 + QE_W'(fix)) : val3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
    if (en1 && in_valid) begin
      op1 <= op_t'(opcode);
      a1  <= a_in;
      b1  <= b_in;
    end
    if (en2 && v1) begin
      op2   <= op1;
      val2  <= tot;
      prod2 <= PROD_W'(a1) * PROD_W'(b1);
      b2    <= b1;
      dz2   <= (op1 == OP_DIV) && (b1 == '0);
    end
    if (en3 && v2) begin
      op3   <= op2;
      val3  <= val2;
      prod3 <= prod2;
      qe3   <= mq[60:RECIP_SHIFT];
      b3    <= b2;
      dz3   <= dz2;
    end
    if (en4 && v3) begin
      out_word.op  <= op3;
      out_word.dz  <= dz3;
      out_word.val <= mval;
      out_word.rem <= '0;
      out_word.dvs <= b3;
    end
  end

endmodule

// ===== sv/dfpa_cell.sv =====
module dfpa_cell import dfpa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dfpa_word_t in_word,
  output logic       out_valid,
  input  logic       out_ready,
  output dfpa_word_t out_word
);

  logic          v;
  logic [HUND_W:0] t, d;
  logic          ge;
  dfpa_word_t    nxt;

  assign in_ready  = !v || out_ready;
  assign out_valid = v;

  always_comb begin
    nxt = in_word;
    t   = {in_word.rem, in_word.val[DVD_W-1]};
    d   = t - {1'b0, in_word.dvs};
    ge  = (t >= {1'b0, in_word.dvs});
    if (in_word.op == OP_DIV) begin
      nxt.rem = ge ? d[HUND_W-1:0] : t[HUND_W-1:0];
      nxt.val = {in_word.val[TOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
    if (in_ready && in_valid) out_word <= nxt;
  end

endmodule

// ===== sv/dfpa_back.sv =====
module dfpa_back import dfpa_pkg::*; #(
  parameter int FRAC_FIELD_BITS = FRAC_BITS_DEF,
  parameter int INT_FIELD_BITS  = INT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dfpa_word_t        in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] result_word,
  output logic              overflow_flag,
  output logic              divide_by_zero_flag
);

  localparam logic [63:0] IMASK = (INT_FIELD_BITS >= 63) ? '1 :
    (64'd1 << INT_FIELD_BITS) - 64'd1;

  logic v1, v2, en1, en2;
  logic [IP_W-1:0]  qe1;
  logic [7:0]       t1;
  logic             dz1;

  logic [TOT_W-1:0] tsel;
  logic [53:0]      mq;
  logic [7:0]       r8, fp;
  logic             fix;
  logic [IP_W-1:0]  ip, ipm;
  logic [31:0]      pk;

  assign en2 = !v2 || out_ready;
  assign en1 = !v1 || en2;
  assign in_ready  = en1;
  assign out_valid = v2;

  always_comb begin
    if (in_word.op == OP_DIV) begin
      tsel = in_word.dz ? '0 : TOT_W'(in_word.val[DVD_W-1:0]);
    end else begin
      tsel = in_word.val;
    end
    mq  = 54'(tsel[TOT_W-1:2]) * 54'(RECIP25);
    r8  = t1 - 8'(qe1[7:0] * HUNDRED8);
    fix = (r8 >= HUNDRED8);
    fp  = fix ? r8 - HUNDRED8 : r8;
    ip  = qe1 + IP_W'(fix);
    ipm = ip & IMASK[IP_W-1:0];
    pk  = (32'(ipm) << FRAC_FIELD_BITS) | 32'(fp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
    if (en1 && in_valid) begin
      qe1 <= mq[RECIP_SHIFT+IP_W-1:RECIP_SHIFT];
      t1  <= tsel[7:0];
      dz1 <= in_word.dz;
    end
    if (en2 && v1) begin
      result_word         <= pk[WORD_W-1:0];
      overflow_flag       <= (64'(ip) > IMASK);
      divide_by_zero_flag <= dz1;
    end
  end

endmodule
